>>> rtl/text_console_char_engine_unit_assert.svh
// assertion macros for the console engine, clocked on aclk, held off during reset
`ifndef TEXT_CONSOLE_CHAR_ENGINE_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_ENGINE_UNIT_ASSERT_SVH

// condition that must hold at every edge out of reset
`define TCCE_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("console engine invariant violated");

// antecedent implies consequent in the same cycle
`define TCCE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("console engine implication violated");

`endif

>>> rtl/tcce_pkg.sv
package tcce_pkg;

    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int TAB_WIDTH = 8;

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int CELL_AW   = $clog2(CELLS);
    localparam int COL_AW    = $clog2(COLUMNS);
    localparam int ROW_AW    = (ROWS > 2) ? $clog2(ROWS) : 1;
    localparam int COL_W     = $clog2(COLUMNS + TAB_WIDTH + 1);
    localparam int ROW_W     = $clog2(ROWS + 1);
    localparam int POS_W     = ((CELL_AW > 11) ? CELL_AW : 11) + 1;
    localparam int SUM_W     = POS_W + 1;
    localparam int TAB_STOPS = (COLUMNS - 1) / TAB_WIDTH + 1;

    localparam int BS_HOLD_COLUMN = 8;

    localparam logic [15:0] BLANK_CELL   = 16'h0F20;
    localparam logic [7:0]  DEFAULT_ATTR = 8'h0F;

    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_PRINT_LO = 8'h20;

    typedef enum logic [1:0] {
        FUNC_PUT_COLOUR  = 2'd0,
        FUNC_PUT_DEFAULT = 2'd1,
        FUNC_CLEAR       = 2'd2,
        FUNC_READ        = 2'd3
    } func_t;

    typedef struct packed {
        func_t       func;
        logic [7:0]  char_code;
        logic [3:0]  back_colour;
        logic [3:0]  fore_colour;
        logic [10:0] cell_index;
    } req_t;

    typedef struct packed {
        logic [10:0] cursor_position;
        logic [15:0] cell_value;
    } res_t;

    typedef struct packed {
        logic [COL_AW-1:0]  col;
        logic [ROW_AW-1:0]  row;
        logic [CELL_AW-1:0] base;
    } cursor_t;

    typedef struct packed {
        logic [COL_AW-1:0]  col;
        logic [ROW_AW-1:0]  row;
        logic               we;
        logic               re;
        logic [CELL_AW-1:0] addr;
        logic [15:0]        wdata;
        logic               scroll;
        logic               clear;
    } step_t;

    typedef struct packed {
        logic               we;
        logic               re;
        logic [CELL_AW-1:0] addr;
        logic [15:0]        wdata;
    } ram_req_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CALC,
        ST_ACCESS,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    function automatic logic [POS_W-1:0] lin_index(input logic [ROW_AW-1:0] row,
                                                   input logic [COL_AW-1:0] col);
        return POS_W'(row) * POS_W'(COLUMNS) + POS_W'(col);
    endfunction

    function automatic logic [CELL_AW-1:0] phys_addr(input logic [POS_W-1:0] lin,
                                                     input logic [CELL_AW-1:0] base);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, lin} + SUM_W'(base);
        if (sum >= SUM_W'(CELLS)) begin
            sum = sum - SUM_W'(CELLS);
        end
        return sum[CELL_AW-1:0];
    endfunction

    function automatic logic [COL_W-1:0] tab_stop(input logic [COL_AW-1:0] col);
        logic [COL_W-1:0] r;
        r = COL_W'(TAB_WIDTH);
        for (int k = 0; k < TAB_STOPS; k++) begin
            if (COL_W'(col) >= COL_W'(k * TAB_WIDTH)) begin
                r = COL_W'((k + 1) * TAB_WIDTH);
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/tcce_cell_ram.sv
module tcce_cell_ram (
    input  logic              aclk,
    input  tcce_pkg::ram_req_t ram_req,
    output logic [15:0]       rdata
);
    import tcce_pkg::*;

    logic [15:0] mem [CELLS];

    always_ff @(posedge aclk) begin
        if (ram_req.we) begin
            mem[ram_req.addr] <= ram_req.wdata;
        end
        if (ram_req.re) begin
            rdata <= mem[ram_req.addr];
        end
    end

endmodule

>>> rtl/tcce_step_logic.sv
module tcce_step_logic (
    input  tcce_pkg::req_t    req,
    input  tcce_pkg::cursor_t cur,
    output tcce_pkg::step_t   step
);
    import tcce_pkg::*;

    logic [COL_W-1:0]  col_n;
    logic [ROW_W-1:0]  row_n;
    logic [COL_AW-1:0] wr_col;
    logic [7:0]        attr;
    logic              erasing;
    logic              put;
    logic              we;
    logic [15:0]       wdata;
    logic              scroll;
    logic              in_range;
    logic [CELL_AW-1:0] wr_addr;
    logic [CELL_AW-1:0] rd_addr;

    always_comb begin
        col_n    = COL_W'(cur.col);
        row_n    = ROW_W'(cur.row);
        wr_col   = cur.col;
        we       = 1'b0;
        wdata    = BLANK_CELL;
        scroll   = 1'b0;
        put      = 1'b0;
        erasing  = 1'b0;
        attr     = {req.back_colour, req.fore_colour};
        in_range = (POS_W'(req.cell_index) < POS_W'(CELLS));

        unique case (req.func)
            FUNC_PUT_COLOUR: begin
                put = 1'b1;
            end
            FUNC_PUT_DEFAULT: begin
                put     = 1'b1;
                erasing = 1'b1;
                attr    = DEFAULT_ATTR;
            end
            FUNC_CLEAR: begin
                col_n = '0;
                row_n = '0;
            end
            FUNC_READ: begin
            end
            default: begin
            end
        endcase

        if (put) begin
            if (req.char_code == CH_BS && cur.col != '0) begin
                if (erasing) begin
                    col_n  = COL_W'(cur.col) - COL_W'(1);
                    wr_col = cur.col - COL_AW'(1);
                    we     = 1'b1;
                    wdata  = BLANK_CELL;
                end else if (COL_W'(cur.col) != COL_W'(BS_HOLD_COLUMN)) begin
                    col_n = COL_W'(cur.col) - COL_W'(1);
                end
            end else if (req.char_code == CH_TAB) begin
                col_n = tab_stop(cur.col);
            end else if (req.char_code == CH_CR) begin
                col_n = '0;
            end else if (req.char_code == CH_LF) begin
                col_n = '0;
                row_n = row_n + ROW_W'(1);
            end else if (req.char_code >= CH_PRINT_LO && !req.char_code[7]) begin
                we    = 1'b1;
                wdata = {attr, req.char_code};
                col_n = col_n + COL_W'(1);
            end
            if (col_n >= COL_W'(COLUMNS)) begin
                col_n = '0;
                row_n = row_n + ROW_W'(1);
            end
            if (row_n >= ROW_W'(ROWS)) begin
                row_n  = ROW_W'(ROWS - 1);
                scroll = 1'b1;
            end
        end

        wr_addr = phys_addr(lin_index(cur.row, wr_col), cur.base);
        rd_addr = phys_addr(POS_W'(req.cell_index), cur.base);

        step.col    = col_n[COL_AW-1:0];
        step.row    = row_n[ROW_AW-1:0];
        step.we     = we;
        step.re     = (req.func == FUNC_READ) && in_range;
        step.addr   = (req.func == FUNC_READ) ? rd_addr : wr_addr;
        step.wdata  = wdata;
        step.scroll = scroll;
        step.clear  = (req.func == FUNC_CLEAR);
    end

endmodule

>>> rtl/text_console_char_engine_unit.sv
// text console character engine, 80 columns by 25 rows of 16-bit cells
// (attribute in the high byte, character in the low byte) plus a cursor.
// s_valid/s_ready/s_req carries one request: put with colours, put in
// default colours, clear, or read a cell. m_valid/m_ready/m_res returns one
// result per request: the cursor position row*80+column and, for a read
// of a cell below 2000, the cell contents (zero otherwise).
// a request is worked in order: decode and address, one access to the cell
// memory, result load; the next request is accepted after the result load.
// rows are kept as a ring over the memory, so a scroll only blanks the new
// bottom row, and a clear rewrites every cell; either sweep runs between the
// access and the result load.
// after reset the block blanks all 2000 cells, one per cycle, before it
// raises s_ready; the cursor starts at the top left.
// while m_ready is low the finished result holds in the output register;
// the next request is still accepted and worked, then waits for the slot.
module text_console_char_engine_unit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  tcce_pkg::req_t s_req,
    output logic           m_valid,
    input  logic           m_ready,
    output tcce_pkg::res_t m_res
);
    import tcce_pkg::*;

    state_t             state_reg, state_next;
    req_t               req_reg, req_next;
    step_t              step_reg, step_next;
    logic [COL_AW-1:0]  col_reg, col_next;
    logic [ROW_AW-1:0]  row_reg, row_next;
    logic [CELL_AW-1:0] base_reg, base_next;
    logic [CELL_AW-1:0] sweep_addr_reg, sweep_addr_next;
    logic [CELL_AW-1:0] sweep_end_reg, sweep_end_next;
    logic               m_valid_reg, m_valid_next;
    res_t               m_res_reg, m_res_next;

    cursor_t            cur;
    step_t              step;
    ram_req_t           ram_req;
    logic [15:0]        rdata;
    logic [CELL_AW:0]   base_inc;
    logic [POS_W-1:0]   pos_lin;

    assign cur.col  = col_reg;
    assign cur.row  = row_reg;
    assign cur.base = base_reg;

    tcce_step_logic u_step (
        .req  (req_reg),
        .cur  (cur),
        .step (step)
    );

    tcce_cell_ram u_ram (
        .aclk    (aclk),
        .ram_req (ram_req),
        .rdata   (rdata)
    );

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        step_next       = step_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        base_next       = base_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_end_next  = sweep_end_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_res_next      = m_res_reg;
        s_ready         = 1'b0;
        ram_req         = '0;
        base_inc        = {1'b0, base_reg} + (CELL_AW + 1)'(COLUMNS);
        pos_lin         = lin_index(row_reg, col_reg);

        unique case (state_reg) inside
            ST_INIT, ST_SWEEP: begin
                ram_req.we    = 1'b1;
                ram_req.addr  = sweep_addr_reg;
                ram_req.wdata = BLANK_CELL;
                sweep_addr_next = sweep_addr_reg + CELL_AW'(1);
                if (sweep_addr_reg == sweep_end_reg) begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_FINISH;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_next   = s_req;
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                step_next = step;
                col_next  = step.col;
                row_next  = step.row;
                if (step.clear) begin
                    base_next       = '0;
                    sweep_addr_next = '0;
                    sweep_end_next  = CELL_AW'(CELLS - 1);
                end else if (step.scroll) begin
                    base_next       = (base_inc >= (CELL_AW + 1)'(CELLS)) ? '0
                                                                         : base_inc[CELL_AW-1:0];
                    sweep_addr_next = base_reg;
                    sweep_end_next  = base_reg + CELL_AW'(COLUMNS - 1);
                end
                state_next = ST_ACCESS;
            end
            ST_ACCESS: begin
                ram_req.we    = step_reg.we;
                ram_req.re    = step_reg.re;
                ram_req.addr  = step_reg.addr;
                ram_req.wdata = step_reg.wdata;
                state_next    = (step_reg.scroll || step_reg.clear) ? ST_SWEEP : ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next               = 1'b1;
                    m_res_next.cursor_position = pos_lin[10:0];
                    m_res_next.cell_value      = step_reg.re ? rdata : 16'h0000;
                    state_next                 = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            col_reg        <= '0;
            row_reg        <= '0;
            base_reg       <= '0;
            sweep_addr_reg <= '0;
            sweep_end_reg  <= CELL_AW'(CELLS - 1);
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            base_reg       <= base_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_end_reg  <= sweep_end_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg   <= req_next;
        step_reg  <= step_next;
        m_res_reg <= m_res_next;
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

`include "text_console_char_engine_unit_assert.svh"

    `TCCE_ASSERT_ALWAYS(a_cursor_in_range,
        (COL_W'(col_reg) < COL_W'(COLUMNS)) && (ROW_W'(row_reg) < ROW_W'(ROWS)))
    `TCCE_ASSERT_ALWAYS(a_base_in_range, SUM_W'(base_reg) < SUM_W'(CELLS))
    `TCCE_ASSERT_IMPL(a_sweep_bounded,
        (state_reg == ST_INIT) || (state_reg == ST_SWEEP), sweep_addr_reg <= sweep_end_reg)
    `TCCE_ASSERT_IMPL(a_result_from_finish, $rose(m_valid_reg), $past(state_reg == ST_FINISH))

endmodule

>>> tb/text_console_char_engine_unit_tb.sv
module text_console_char_engine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcce_pkg::*;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_req   = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    res_t m_res;

    text_console_char_engine_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    logic [15:0]      screen_image [CELLS];
    logic [COL_W-1:0] model_col;
    logic [ROW_W-1:0] model_row;
    res_t             expected_results [$];
    int               error_count     = 0;
    bit               no_idle         = 1'b0;
    int               hold_off_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic void blank_screen_image();
        for (int i = 0; i < CELLS; i++) begin
            screen_image[i] = BLANK_CELL;
        end
        model_col = '0;
        model_row = '0;
    endfunction

    // advances the console image by one request and returns its result
    function automatic res_t console_step(input req_t r);
        res_t        res;
        logic [7:0]  attr;
        logic [15:0] value;
        int          stop;
        value = '0;
        attr  = (r.func == FUNC_PUT_COLOUR) ? {r.back_colour, r.fore_colour} : DEFAULT_ATTR;
        case (r.func) inside
            FUNC_PUT_COLOUR, FUNC_PUT_DEFAULT: begin
                if (r.char_code == CH_BS && model_col != 0) begin
                    if (r.func == FUNC_PUT_DEFAULT) begin
                        model_col--;
                        screen_image[int'(model_row) * COLUMNS + int'(model_col)] = BLANK_CELL;
                    end else if (model_col != COL_W'(BS_HOLD_COLUMN)) begin
                        model_col--;
                    end
                end else if (r.char_code == CH_TAB) begin
                    stop      = int'(model_col) + TAB_WIDTH;
                    model_col = COL_W'(stop - stop % TAB_WIDTH);
                end else if (r.char_code == CH_CR) begin
                    model_col = '0;
                end else if (r.char_code == CH_LF) begin
                    model_col = '0;
                    model_row++;
                end else if (r.char_code >= CH_PRINT_LO && !r.char_code[7]) begin
                    screen_image[int'(model_row) * COLUMNS + int'(model_col)] =
                        {attr, r.char_code};
                    model_col++;
                end
                // column wrap, then scroll when the cursor falls off the bottom
                if (int'(model_col) >= COLUMNS) begin
                    model_col = '0;
                    model_row++;
                end
                if (int'(model_row) >= ROWS) begin
                    for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
                        screen_image[i] = screen_image[i + COLUMNS];
                    end
                    for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) begin
                        screen_image[i] = BLANK_CELL;
                    end
                    model_row = ROW_W'(ROWS - 1);
                end
            end
            FUNC_CLEAR: begin
                blank_screen_image();
            end
            default: begin
                if (int'(r.cell_index) < CELLS) begin
                    value = screen_image[r.cell_index];
                end
            end
        endcase
        res.cursor_position = 11'(int'(model_row) * COLUMNS + int'(model_col));
        res.cell_value      = value;
        return res;
    endfunction

    task automatic send_request(input req_t r);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= r;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(console_step(r));
    endtask

    task automatic put_colour(input logic [7:0] ch, input logic [3:0] bg, input logic [3:0] fg);
        send_request('{func: FUNC_PUT_COLOUR, char_code: ch, back_colour: bg,
                       fore_colour: fg, cell_index: 11'($urandom)});
    endtask

    task automatic put_default(input logic [7:0] ch);
        send_request('{func: FUNC_PUT_DEFAULT, char_code: ch, back_colour: 4'($urandom),
                       fore_colour: 4'($urandom), cell_index: 11'($urandom)});
    endtask

    task automatic read_cell(input logic [10:0] idx);
        send_request('{func: FUNC_READ, char_code: 8'($urandom), back_colour: 4'($urandom),
                       fore_colour: 4'($urandom), cell_index: idx});
    endtask

    task automatic clear_screen();
        send_request('{func: FUNC_CLEAR, char_code: 8'($urandom), back_colour: 4'($urandom),
                       fore_colour: 4'($urandom), cell_index: 11'($urandom)});
    endtask

    // mostly text with line control, reads near the cursor row, rare clears
    function automatic req_t random_request();
        req_t r;
        int   pick;
        r.char_code = 8'($urandom_range(8'h20, 8'h7F));
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            r.char_code = CH_LF;
        end else if (pick < 23) begin
            r.char_code = CH_TAB;
        end else if (pick < 27) begin
            r.char_code = CH_CR;
        end else if (pick < 38) begin
            r.char_code = CH_BS;
        end else if (pick < 46) begin
            r.char_code = 8'($urandom);
        end
        r.back_colour = 4'($urandom);
        r.fore_colour = 4'($urandom);
        r.cell_index  = 11'($urandom);
        pick = $urandom_range(0, 999);
        if (pick < 2) begin
            r.func = FUNC_CLEAR;
        end else if (pick < 230) begin
            r.func = FUNC_READ;
            if (pick < 150) begin
                r.cell_index = 11'(int'(model_row) * COLUMNS +
                                   int'($urandom_range(0, COLUMNS - 1)));
            end
        end else if (pick < 620) begin
            r.func = FUNC_PUT_COLOUR;
        end else begin
            r.func = FUNC_PUT_DEFAULT;
        end
        return r;
    endfunction

    task automatic test_reset_contents();
        read_cell(11'd0);
        read_cell(11'(CELLS - 1));
        read_cell(11'h7FF);
    endtask

    task automatic test_put_characters();
        put_colour(8'h41, 4'hF, 4'h0);
        put_colour(8'h7F, 4'h0, 4'hF);
        put_colour(8'h80, 4'hA, 4'h5);
        put_colour(8'hFF, 4'h5, 4'hA);
        put_default(8'h00);
        put_default(8'h1F);
        put_default(8'h20);
        read_cell(11'd0);
        read_cell(11'd1);
    endtask

    task automatic test_cursor_controls();
        put_colour(CH_TAB, 4'h1, 4'h2);
        put_colour(CH_BS, 4'h1, 4'h2);
        put_default(8'h78);
        put_colour(8'h79, 4'h3, 4'hC);
        put_colour(CH_BS, 4'h3, 4'hC);
        put_default(CH_BS);
        read_cell(11'd8);
        read_cell(11'd9);
        put_colour(CH_CR, 4'h0, 4'h0);
        put_default(CH_BS);
        put_colour(CH_LF, 4'hF, 4'hF);
    endtask

    task automatic test_wrap_and_scroll();
        put_colour(CH_CR, 4'($urandom), 4'($urandom));
        repeat (COLUMNS / TAB_WIDTH) put_default(CH_TAB);
        for (int i = 0; i < COLUMNS; i++) begin
            put_colour(8'($urandom_range(8'h20, 8'h7F)), 4'($urandom), 4'($urandom));
        end
        repeat (ROWS + 2) put_default(CH_LF);
        // full lines typed on the bottom row push it up
        repeat (2) begin
            for (int i = 0; i < COLUMNS; i++) begin
                put_colour(8'($urandom_range(8'h20, 8'h7F)), 4'($urandom), 4'($urandom));
            end
        end
        read_cell(11'((ROWS - 2) * COLUMNS));
        read_cell(11'((ROWS - 1) * COLUMNS - 1));
        read_cell(11'((ROWS - 1) * COLUMNS));
        repeat (4) read_cell(11'($urandom_range(0, CELLS - 1)));
    endtask

    task automatic test_clear_screen();
        repeat (3) put_colour(8'($urandom_range(8'h20, 8'h7F)), 4'($urandom), 4'($urandom));
        clear_screen();
        read_cell(11'd0);
        read_cell(11'(CELLS - 1));
        put_default(8'h61);
        read_cell(11'd0);
    endtask

    task automatic test_backpressure();
        hold_off_cycles = 400;
        repeat (30) send_request(random_request());
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_request(random_request());
    endtask

    task automatic test_final_burst();
        no_idle = 1'b1;
        repeat (200) send_request(random_request());
    endtask

    // result side: random stalls, plus one long hold when asked
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge aclk);
                hold_off_cycles = 0;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with no request pending: cursor_position=%0d cell_value=%h",
                       m_res.cursor_position, m_res.cell_value);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_res.cursor_position !== want.cursor_position) begin
                    $error("cursor_position expected %0d actual %0d",
                           want.cursor_position, m_res.cursor_position);
                    error_count++;
                end
                if (m_res.cell_value !== want.cell_value) begin
                    $error("cell_value expected %h actual %h",
                           want.cell_value, m_res.cell_value);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #100_000_000;
        $display("[text_console_char_engine_unit] ERROR");
        $finish;
    end

    initial begin
        blank_screen_image();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_contents();
        test_put_characters();
        test_cursor_controls();
        test_wrap_and_scroll();
        test_clear_screen();
        test_backpressure();
        test_random_traffic(1550);
        test_final_burst();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("[text_console_char_engine_unit] OK");
        end else begin
            $display("[text_console_char_engine_unit] ERROR");
        end
        $finish;
    end

endmodule
